[hdl/gifp_pkg.sv]
// Shared types and constants for the GIF header and transparency parser.
// No dependencies; used by every module of the block except gifp_ram.
package gifp_pkg;

    localparam int MAP_ENTRIES_DEF = 256;

    typedef enum logic [3:0] {
        PH_SIG,
        PH_SCREEN,
        PH_GMAP,
        PH_BLOCKS,
        PH_EXTLABEL,
        PH_EXTSIZE,
        PH_EXTDATA,
        PH_IMGDESC,
        PH_LMAP,
        PH_DONE
    } phase_t;

    localparam logic [2:0] ST_IMAGE     = 3'd0;
    localparam logic [2:0] ST_TERM      = 3'd1;
    localparam logic [2:0] ST_BADSIG    = 3'd2;
    localparam logic [2:0] ST_TRUNC     = 3'd3;
    localparam logic [2:0] ST_LMAPTRUNC = 3'd4;

    localparam logic [7:0] CH_G       = 8'h47;
    localparam logic [7:0] CH_I       = 8'h49;
    localparam logic [7:0] CH_F       = 8'h46;
    localparam logic [7:0] CH_8       = 8'h38;
    localparam logic [7:0] CH_7       = 8'h37;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_A       = 8'h61;
    localparam logic [7:0] CH_TERM    = 8'h3b;
    localparam logic [7:0] CH_EXT     = 8'h21;
    localparam logic [7:0] CH_IMG     = 8'h2c;
    localparam logic [7:0] LABEL_GCE  = 8'hf9;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] screen_width;
        logic [15:0] screen_height;
        logic [7:0]  background_index;
        logic [3:0]  color_resolution;
        logic        local_map_used;
        logic        transparent_valid;
        logic [7:0]  transparent_index;
        logic [23:0] transparent_rgb;
        logic [2:0]  disposal_method;
        logic        user_input_flag;
        logic [15:0] delay_time;
    } result_t;

    typedef struct packed {
        logic        valid;
        logic        hit;
        logic        bypass;
        logic [23:0] bypass_data;
        result_t     res;
    } req_t;

    function automatic logic [8:0] map_size(input logic [7:0] packed_flags);
        map_size = 9'd2 << packed_flags[2:0];
    endfunction

endpackage

[hdl/gifp_ram.sv]
// Generic single-port-write, registered-read RAM.
// No dependencies.
module gifp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/gifp_front.sv]
// Byte parser: signature, screen descriptor, maps, extensions, image descriptor.
// Depends on gifp_pkg; drives the map RAM and issues result requests.
module gifp_front #(
    parameter int MAP_ENTRIES = gifp_pkg::MAP_ENTRIES_DEF,
    localparam int AW = $clog2(MAP_ENTRIES)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  logic               action,
    input  logic [7:0]         data_byte,
    output logic               ram_we,
    output logic [AW-1:0]      ram_waddr,
    output logic [23:0]        ram_wdata,
    output logic               ram_re,
    output logic [AW-1:0]      ram_raddr,
    output gifp_pkg::req_t     req
);

    gifp_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  fc_reg, fc_next;
    logic [7:0]  sbr_reg, sbr_next;
    logic        first_reg, first_next;
    logic [7:0]  label_reg, label_next;
    logic [8:0]  cnt_reg, cnt_next;
    logic [15:0] rgb_reg, rgb_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic [7:0]  flags_reg, flags_next;
    logic [7:0]  bg_reg, bg_next;
    logic [2:0]  disp_reg, disp_next;
    logic        uin_reg, uin_next;
    logic [15:0] delay_reg, delay_next;
    logic        tvalid_reg, tvalid_next;
    logic [7:0]  tindex_reg, tindex_next;
    logic        local_reg, local_next;

    logic        emit;
    logic        emit_full;
    logic [2:0]  emit_status;
    logic        sig_ok;
    logic        map_done;
    logic [8:0]  target;
    logic [8:0]  loaded;
    logic        hit;

    always_comb
    begin
        phase_next  = phase_reg;
        fc_next     = fc_reg;
        sbr_next    = sbr_reg;
        first_next  = first_reg;
        label_next  = label_reg;
        cnt_next    = cnt_reg;
        rgb_next    = rgb_reg;
        width_next  = width_reg;
        height_next = height_reg;
        flags_next  = flags_reg;
        bg_next     = bg_reg;
        disp_next   = disp_reg;
        uin_next    = uin_reg;
        delay_next  = delay_reg;
        tvalid_next = tvalid_reg;
        tindex_next = tindex_reg;
        local_next  = local_reg;
        emit        = 1'b0;
        emit_full   = 1'b0;
        emit_status = gifp_pkg::ST_IMAGE;
        sig_ok      = 1'b1;
        map_done    = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = cnt_reg[AW-1:0];
        ram_wdata   = {rgb_reg, data_byte};
        target      = (phase_reg == gifp_pkg::PH_LMAP) ? gifp_pkg::map_size(label_reg)
                                                       : gifp_pkg::map_size(flags_reg);

        // shared map byte handling for global and local maps
        if (take && !action
            && (phase_reg == gifp_pkg::PH_GMAP || phase_reg == gifp_pkg::PH_LMAP))
        begin
            if (fc_reg < 4'd2)
            begin
                rgb_next = {rgb_reg[7:0], data_byte};
                fc_next  = fc_reg + 4'd1;
            end
            else
            begin
                ram_we   = cnt_reg < 9'(MAP_ENTRIES);
                cnt_next = cnt_reg + 9'd1;
                fc_next  = 4'd0;
                rgb_next = 16'd0;
                map_done = (cnt_reg + 9'd1) >= target;
            end
        end

        if (take)
        begin
            if (action)
            begin
                if (phase_reg == gifp_pkg::PH_LMAP)
                begin
                    emit        = 1'b1;
                    emit_full   = 1'b1;
                    emit_status = gifp_pkg::ST_LMAPTRUNC;
                end
                else if (phase_reg != gifp_pkg::PH_DONE)
                begin
                    emit        = 1'b1;
                    emit_status = gifp_pkg::ST_TRUNC;
                end
            end
            else
            begin
                case (phase_reg)
                    gifp_pkg::PH_SIG:
                    begin
                        case (fc_reg)
                            4'd0:    sig_ok = data_byte == gifp_pkg::CH_G;
                            4'd1:    sig_ok = data_byte == gifp_pkg::CH_I;
                            4'd2:    sig_ok = data_byte == gifp_pkg::CH_F;
                            4'd3:    sig_ok = data_byte == gifp_pkg::CH_8;
                            4'd4:    sig_ok = data_byte == gifp_pkg::CH_7
                                              || data_byte == gifp_pkg::CH_9;
                            default: sig_ok = data_byte == gifp_pkg::CH_A;
                        endcase
                        // first_sub_block doubles as the bad-signature mark
                        if (!sig_ok)
                        begin
                            first_next = 1'b1;
                        end
                        if (fc_reg >= 4'd5)
                        begin
                            fc_next = 4'd0;
                            if (first_next)
                            begin
                                first_next  = 1'b0;
                                phase_next  = gifp_pkg::PH_DONE;
                                emit        = 1'b1;
                                emit_status = gifp_pkg::ST_BADSIG;
                            end
                            else
                            begin
                                phase_next = gifp_pkg::PH_SCREEN;
                            end
                        end
                        else
                        begin
                            fc_next = fc_reg + 4'd1;
                        end
                    end
                    gifp_pkg::PH_SCREEN:
                    begin
                        case (fc_reg)
                            4'd0:    width_next  = {8'd0, data_byte};
                            4'd1:    width_next  = {data_byte, width_reg[7:0]};
                            4'd2:    height_next = {8'd0, data_byte};
                            4'd3:    height_next = {data_byte, height_reg[7:0]};
                            4'd4:    flags_next  = data_byte;
                            4'd5:    bg_next     = data_byte;
                            default: ;
                        endcase
                        if (fc_reg >= 4'd6)
                        begin
                            fc_next    = 4'd0;
                            cnt_next   = 9'd0;
                            phase_next = flags_reg[7] ? gifp_pkg::PH_GMAP
                                                      : gifp_pkg::PH_BLOCKS;
                        end
                        else
                        begin
                            fc_next = fc_reg + 4'd1;
                        end
                    end
                    gifp_pkg::PH_GMAP:
                    begin
                        if (map_done)
                        begin
                            phase_next = gifp_pkg::PH_BLOCKS;
                        end
                    end
                    gifp_pkg::PH_BLOCKS:
                    begin
                        if (data_byte == gifp_pkg::CH_TERM)
                        begin
                            phase_next  = gifp_pkg::PH_DONE;
                            emit        = 1'b1;
                            emit_full   = 1'b1;
                            emit_status = gifp_pkg::ST_TERM;
                        end
                        else if (data_byte == gifp_pkg::CH_EXT)
                        begin
                            phase_next = gifp_pkg::PH_EXTLABEL;
                        end
                        else if (data_byte == gifp_pkg::CH_IMG)
                        begin
                            fc_next    = 4'd0;
                            phase_next = gifp_pkg::PH_IMGDESC;
                        end
                    end
                    gifp_pkg::PH_EXTLABEL:
                    begin
                        label_next = data_byte;
                        first_next = 1'b1;
                        phase_next = gifp_pkg::PH_EXTSIZE;
                    end
                    gifp_pkg::PH_EXTSIZE:
                    begin
                        if (data_byte == 8'd0)
                        begin
                            first_next = 1'b0;
                            phase_next = gifp_pkg::PH_BLOCKS;
                        end
                        else
                        begin
                            sbr_next   = data_byte;
                            fc_next    = 4'd0;
                            phase_next = gifp_pkg::PH_EXTDATA;
                        end
                    end
                    gifp_pkg::PH_EXTDATA:
                    begin
                        if (first_reg && label_reg == gifp_pkg::LABEL_GCE)
                        begin
                            case (fc_reg)
                                4'd0:
                                begin
                                    disp_next = data_byte[4:2];
                                    uin_next  = data_byte[1];
                                    rgb_next  = {15'd0, data_byte[0]};
                                end
                                4'd1: delay_next = {delay_reg[15:8], data_byte};
                                4'd2: delay_next = {data_byte, delay_reg[7:0]};
                                4'd3:
                                begin
                                    if (rgb_reg[0])
                                    begin
                                        tvalid_next = 1'b1;
                                        tindex_next = data_byte;
                                    end
                                end
                                default: ;
                            endcase
                        end
                        // saturate: only the first four positions matter
                        if (fc_reg != 4'hf)
                        begin
                            fc_next = fc_reg + 4'd1;
                        end
                        sbr_next = sbr_reg - 8'd1;
                        if (sbr_next == 8'd0)
                        begin
                            first_next = 1'b0;
                            fc_next    = 4'd0;
                            rgb_next   = 16'd0;
                            phase_next = gifp_pkg::PH_EXTSIZE;
                        end
                    end
                    gifp_pkg::PH_IMGDESC:
                    begin
                        if (fc_reg >= 4'd8)
                        begin
                            fc_next = 4'd0;
                            if (data_byte[7])
                            begin
                                local_next = 1'b1;
                                label_next = data_byte;
                                cnt_next   = 9'd0;
                                rgb_next   = 16'd0;
                                phase_next = gifp_pkg::PH_LMAP;
                            end
                            else
                            begin
                                phase_next  = gifp_pkg::PH_DONE;
                                emit        = 1'b1;
                                emit_full   = 1'b1;
                                emit_status = gifp_pkg::ST_IMAGE;
                            end
                        end
                        else
                        begin
                            fc_next = fc_reg + 4'd1;
                        end
                    end
                    gifp_pkg::PH_LMAP:
                    begin
                        if (map_done)
                        begin
                            phase_next  = gifp_pkg::PH_DONE;
                            emit        = 1'b1;
                            emit_full   = 1'b1;
                            emit_status = gifp_pkg::ST_IMAGE;
                        end
                    end
                    default: ;
                endcase
            end
        end

        // transparent lookup against the part of the map in use that is loaded
        if (local_next)
        begin
            loaded = cnt_next;
        end
        else
        begin
            loaded = flags_next[7] ? gifp_pkg::map_size(flags_next) : 9'd0;
        end
        if (loaded > 9'(MAP_ENTRIES))
        begin
            loaded = 9'(MAP_ENTRIES);
        end
        hit = tvalid_next && ({1'b0, tindex_next} < loaded);

        ram_raddr = tindex_next[AW-1:0];
        ram_re    = emit && emit_full && hit;

        req.valid       = emit;
        req.hit         = emit_full && hit;
        req.bypass      = ram_we && (ram_waddr == ram_raddr);
        req.bypass_data = ram_wdata;
        req.res         = '0;
        req.res.status  = emit_status;
        if (emit_full)
        begin
            req.res.screen_width      = width_next;
            req.res.screen_height     = height_next;
            req.res.background_index  = bg_next;
            req.res.color_resolution  = {flags_next[6:4], 1'b1};
            req.res.local_map_used    = local_next;
            req.res.transparent_valid = tvalid_next;
            req.res.transparent_index = tvalid_next ? tindex_next : 8'd0;
            req.res.disposal_method   = disp_next;
            req.res.user_input_flag   = uin_next;
            req.res.delay_time        = delay_next;
        end

        // end of input returns to the start state
        if (take && action)
        begin
            phase_next  = gifp_pkg::PH_SIG;
            fc_next     = 4'd0;
            sbr_next    = 8'd0;
            first_next  = 1'b0;
            label_next  = 8'd0;
            cnt_next    = 9'd0;
            rgb_next    = 16'd0;
            width_next  = 16'd0;
            height_next = 16'd0;
            flags_next  = 8'd0;
            bg_next     = 8'd0;
            disp_next   = 3'd0;
            uin_next    = 1'b0;
            delay_next  = 16'd0;
            tvalid_next = 1'b0;
            tindex_next = 8'd0;
            local_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= gifp_pkg::PH_SIG;
            fc_reg     <= 4'd0;
            sbr_reg    <= 8'd0;
            first_reg  <= 1'b0;
            label_reg  <= 8'd0;
            cnt_reg    <= 9'd0;
            rgb_reg    <= 16'd0;
            width_reg  <= 16'd0;
            height_reg <= 16'd0;
            flags_reg  <= 8'd0;
            bg_reg     <= 8'd0;
            disp_reg   <= 3'd0;
            uin_reg    <= 1'b0;
            delay_reg  <= 16'd0;
            tvalid_reg <= 1'b0;
            tindex_reg <= 8'd0;
            local_reg  <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            fc_reg     <= fc_next;
            sbr_reg    <= sbr_next;
            first_reg  <= first_next;
            label_reg  <= label_next;
            cnt_reg    <= cnt_next;
            rgb_reg    <= rgb_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            flags_reg  <= flags_next;
            bg_reg     <= bg_next;
            disp_reg   <= disp_next;
            uin_reg    <= uin_next;
            delay_reg  <= delay_next;
            tvalid_reg <= tvalid_next;
            tindex_reg <= tindex_next;
            local_reg  <= local_next;
        end
    end

endmodule

[hdl/gifp_back.sv]
// Result side: merges map read data into a request and queues results.
// Depends on gifp_pkg; takes requests from gifp_front and data from gifp_ram.
module gifp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  gifp_pkg::req_t    req,
    input  logic [23:0]       ram_rdata,
    input  logic              pop,
    output logic              empty,
    output logic              full,
    output gifp_pkg::result_t head
);

    logic                 stage_valid_reg;
    gifp_pkg::req_t       stage_reg;
    gifp_pkg::result_t    stage_res;
    gifp_pkg::result_t    fifo_reg [4];
    logic [1:0]           wptr_reg;
    logic [1:0]           rptr_reg;
    logic [2:0]           count_reg, count_next;
    logic                 do_pop;
    logic [2:0]           occupancy;

    assign do_pop    = pop && (count_reg != 3'd0);
    assign occupancy = count_reg + {2'b0, stage_valid_reg};
    // reserve room for the word still in the lookup stage
    assign full      = occupancy >= 3'd4;
    assign empty     = count_reg == 3'd0;
    assign head      = fifo_reg[rptr_reg];

    always_comb
    begin
        stage_res = stage_reg.res;
        if (stage_reg.hit)
        begin
            stage_res.transparent_rgb = stage_reg.bypass ? stage_reg.bypass_data : ram_rdata;
        end
        else
        begin
            stage_res.transparent_rgb = 24'd0;
        end
        count_next = count_reg + {2'b0, stage_valid_reg} - {2'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            stage_reg <= req;
        end
        if (stage_valid_reg)
        begin
            fifo_reg[wptr_reg] <= stage_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            wptr_reg        <= 2'd0;
            rptr_reg        <= 2'd0;
            count_reg       <= 3'd0;
        end
        else
        begin
            stage_valid_reg <= req.valid;
            count_reg       <= count_next;
            if (stage_valid_reg)
            begin
                wptr_reg <= wptr_reg + 2'd1;
            end
            if (do_pop)
            begin
                rptr_reg <= rptr_reg + 2'd1;
            end
        end
    end

endmodule

[hdl/gif_header_transparency_parser.sv]
// GIF header and transparency parser, top level.
// Takes one word per cycle while full is low; a result passes through the front parse
// and then one registered map read before it is written to the output queue.
// Throughput: one word per cycle while the four-word result queue has room.
// Reset (rst_n low, asynchronous) returns to awaiting the signature and empties
// the queue; the colour map holds no reset and is only read where written.
module gif_header_transparency_parser #(
    parameter int MAP_ENTRIES = gifp_pkg::MAP_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        action,
    input  logic [7:0]  data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  status,
    output logic [15:0] screen_width,
    output logic [15:0] screen_height,
    output logic [7:0]  background_index,
    output logic [3:0]  color_resolution,
    output logic        local_map_used,
    output logic        transparent_valid,
    output logic [7:0]  transparent_index,
    output logic [23:0] transparent_rgb,
    output logic [2:0]  disposal_method,
    output logic        user_input_flag,
    output logic [15:0] delay_time
);

    localparam int AW = $clog2(MAP_ENTRIES);

    logic              take;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [23:0]       ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [23:0]       ram_rdata;
    gifp_pkg::req_t    req;
    gifp_pkg::result_t head;

    assign take = push && !full;

    gifp_front #(
        .MAP_ENTRIES(MAP_ENTRIES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .action    (action),
        .data_byte (data_byte),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .req       (req)
    );

    gifp_ram #(
        .WIDTH(24),
        .DEPTH(MAP_ENTRIES)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    gifp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .ram_rdata (ram_rdata),
        .pop       (pop),
        .empty     (empty),
        .full      (full),
        .head      (head)
    );

    assign status            = head.status;
    assign screen_width      = head.screen_width;
    assign screen_height     = head.screen_height;
    assign background_index  = head.background_index;
    assign color_resolution  = head.color_resolution;
    assign local_map_used    = head.local_map_used;
    assign transparent_valid = head.transparent_valid;
    assign transparent_index = head.transparent_index;
    assign transparent_rgb   = head.transparent_rgb;
    assign disposal_method   = head.disposal_method;
    assign user_input_flag   = head.user_input_flag;
    assign delay_time        = head.delay_time;

endmodule

[dv/tb_gif_header_transparency_parser.sv]
// Testbench for gif_header_transparency_parser: GIF byte streams in, result words out.
// Depends on gifp_pkg and the top level; predicts every result in-line and checks it in order.
module tb_gif_header_transparency_parser;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int TARGET_ITEMS   = 1100;

    typedef struct {
        bit         eoi;
        logic [7:0] b;
    } byte_item_t;

    class result_board;
        gifp_pkg::result_t pending_q[$];
        int                mismatches;

        function void note(gifp_pkg::result_t r);
            pending_q.push_back(r);
        endfunction

        function bit field_ok(string name, logic [31:0] e, logic [31:0] a);
            if (e !== a) begin
                if (mismatches < 10)
                    $display("  %s: expected %0h, actual %0h", name, e, a);
                return 0;
            end
            return 1;
        endfunction

        function void check(gifp_pkg::result_t act);
            gifp_pkg::result_t e;
            bit                ok;
            if (pending_q.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result word, status %0d", act.status);
                mismatches++;
                return;
            end
            e = pending_q.pop_front();
            if (e !== act && mismatches < 10)
                $display("mismatch at %0t:", $realtime);
            ok = field_ok("status", e.status, act.status);
            ok &= field_ok("screen_width", e.screen_width, act.screen_width);
            ok &= field_ok("screen_height", e.screen_height, act.screen_height);
            ok &= field_ok("background_index", e.background_index, act.background_index);
            ok &= field_ok("color_resolution", e.color_resolution, act.color_resolution);
            ok &= field_ok("local_map_used", e.local_map_used, act.local_map_used);
            ok &= field_ok("transparent_valid", e.transparent_valid, act.transparent_valid);
            ok &= field_ok("transparent_index", e.transparent_index, act.transparent_index);
            ok &= field_ok("transparent_rgb", e.transparent_rgb, act.transparent_rgb);
            ok &= field_ok("disposal_method", e.disposal_method, act.disposal_method);
            ok &= field_ok("user_input_flag", e.user_input_flag, act.user_input_flag);
            ok &= field_ok("delay_time", e.delay_time, act.delay_time);
            if (!ok)
                mismatches++;
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        push = 0;
    logic        full;
    logic        action = 0;
    logic [7:0]  data_byte = 0;
    logic        empty;
    logic        pop = 0;
    logic [2:0]  status;
    logic [15:0] screen_width;
    logic [15:0] screen_height;
    logic [7:0]  background_index;
    logic [3:0]  color_resolution;
    logic        local_map_used;
    logic        transparent_valid;
    logic [7:0]  transparent_index;
    logic [23:0] transparent_rgb;
    logic [2:0]  disposal_method;
    logic        user_input_flag;
    logic [15:0] delay_time;

    gif_header_transparency_parser u_dut (.*);

    always #10 clk = ~clk;

    result_board board;
    byte_item_t  stim[$];
    int          burst_start;
    bit          hold_req = 0;
    bit          hold_done = 0;
    int          hold_cnt = 0;
    int          cycle_cnt = 0;
    int          stall_cnt = 0;

    // parser state mirror
    gifp_pkg::phase_t ph;
    logic [9:0]  fcnt;
    logic [7:0]  sbrem;
    bit          first_sb;
    logic [7:0]  ext_label;
    logic [8:0]  mcount;
    logic [15:0] rgbacc;
    logic [15:0] sw, sh;
    logic [7:0]  sflags, sbg;
    logic [2:0]  disp;
    bit          uin;
    logic [15:0] dly;
    bit          tv;
    logic [7:0]  ti;
    bit          lflag;
    logic [23:0] cmap [0:255];

    function automatic int entries_of(logic [7:0] f);
        return 2 << f[2:0];
    endfunction

    function void clear_parser();
        ph = gifp_pkg::PH_SIG; fcnt = 0; sbrem = 0; first_sb = 0; ext_label = 0; mcount = 0;
        rgbacc = 0; sw = 0; sh = 0; sflags = 0; sbg = 0;
        disp = 0; uin = 0; dly = 0; tv = 0; ti = 0; lflag = 0;
    endfunction

    function logic [23:0] transparent_color();
        int loaded;
        if (!tv)
            return 0;
        loaded = lflag ? int'(mcount) : (sflags[7] ? entries_of(sflags) : 0);
        if (loaded > 256)
            loaded = 256;
        if (ti >= loaded)
            return 0;
        return cmap[ti];
    endfunction

    function void report(logic [2:0] st, bit whole);
        gifp_pkg::result_t r;
        r = '0;
        r.status = st;
        if (whole) begin
            r.screen_width      = sw;
            r.screen_height     = sh;
            r.background_index  = sbg;
            r.color_resolution  = 4'({1'b0, sflags[6:4]} * 2 + 1);
            r.local_map_used    = lflag;
            r.transparent_valid = tv;
            r.transparent_index = tv ? ti : 8'h00;
            r.transparent_rgb   = transparent_color();
            r.disposal_method   = disp;
            r.user_input_flag   = uin;
            r.delay_time        = dly;
        end
        board.note(r);
    endfunction

    // returns 1 once the map is complete
    function bit load_map_byte(logic [7:0] b, int target);
        if (fcnt < 2) begin
            rgbacc = {rgbacc[7:0], b};
            fcnt++;
            return 0;
        end
        if (mcount < 256)
            cmap[mcount] = {rgbacc, b};
        mcount++;
        fcnt = 0;
        rgbacc = 0;
        return mcount >= target;
    endfunction

    function void predict(byte_item_t it);
        bit         ok;
        logic [7:0] b;
        b = it.b;
        if (it.eoi) begin
            if (ph == gifp_pkg::PH_LMAP)
                report(gifp_pkg::ST_LMAPTRUNC, 1);
            else if (ph != gifp_pkg::PH_DONE)
                report(gifp_pkg::ST_TRUNC, 0);
            clear_parser();
            return;
        end
        case (ph)
            gifp_pkg::PH_SIG: begin
                case (fcnt)
                    0: ok = (b == gifp_pkg::CH_G);
                    1: ok = (b == gifp_pkg::CH_I);
                    2: ok = (b == gifp_pkg::CH_F);
                    3: ok = (b == gifp_pkg::CH_8);
                    4: ok = (b == gifp_pkg::CH_7 || b == gifp_pkg::CH_9);
                    default: ok = (b == gifp_pkg::CH_A);
                endcase
                if (!ok)
                    first_sb = 1;
                if (fcnt >= 5) begin
                    fcnt = 0;
                    if (first_sb) begin
                        first_sb = 0;
                        ph = gifp_pkg::PH_DONE;
                        report(gifp_pkg::ST_BADSIG, 0);
                    end
                    else
                        ph = gifp_pkg::PH_SCREEN;
                end
                else
                    fcnt++;
            end
            gifp_pkg::PH_SCREEN: begin
                case (fcnt)
                    0: sw = {8'h00, b};
                    1: sw[15:8] = b;
                    2: sh = {8'h00, b};
                    3: sh[15:8] = b;
                    4: sflags = b;
                    5: sbg = b;
                    default: ;
                endcase
                if (fcnt >= 6) begin
                    fcnt = 0;
                    mcount = 0;
                    ph = sflags[7] ? gifp_pkg::PH_GMAP : gifp_pkg::PH_BLOCKS;
                end
                else
                    fcnt++;
            end
            gifp_pkg::PH_GMAP:
                if (load_map_byte(b, entries_of(sflags)))
                    ph = gifp_pkg::PH_BLOCKS;
            gifp_pkg::PH_BLOCKS:
                if (b == gifp_pkg::CH_TERM) begin
                    ph = gifp_pkg::PH_DONE;
                    report(gifp_pkg::ST_TERM, 1);
                end
                else if (b == gifp_pkg::CH_EXT)
                    ph = gifp_pkg::PH_EXTLABEL;
                else if (b == gifp_pkg::CH_IMG) begin
                    fcnt = 0;
                    ph = gifp_pkg::PH_IMGDESC;
                end
            gifp_pkg::PH_EXTLABEL: begin
                ext_label = b;
                first_sb = 1;
                ph = gifp_pkg::PH_EXTSIZE;
            end
            gifp_pkg::PH_EXTSIZE:
                if (b == 0) begin
                    first_sb = 0;
                    ph = gifp_pkg::PH_BLOCKS;
                end
                else begin
                    sbrem = b;
                    fcnt = 0;
                    ph = gifp_pkg::PH_EXTDATA;
                end
            gifp_pkg::PH_EXTDATA: begin
                if (first_sb && ext_label == gifp_pkg::LABEL_GCE) begin
                    case (fcnt)
                        0: begin
                            disp = b[4:2];
                            uin = b[1];
                            rgbacc = {15'd0, b[0]};
                        end
                        1: dly[7:0] = b;
                        2: dly[15:8] = b;
                        3: if (rgbacc[0]) begin
                            tv = 1;
                            ti = b;
                        end
                        default: ;
                    endcase
                end
                if (fcnt < 1023)
                    fcnt++;
                sbrem = sbrem - 8'd1;
                if (sbrem == 0) begin
                    first_sb = 0;
                    fcnt = 0;
                    rgbacc = 0;
                    ph = gifp_pkg::PH_EXTSIZE;
                end
            end
            gifp_pkg::PH_IMGDESC:
                if (fcnt >= 8) begin
                    fcnt = 0;
                    if (b[7]) begin
                        lflag = 1;
                        ext_label = b;
                        mcount = 0;
                        rgbacc = 0;
                        ph = gifp_pkg::PH_LMAP;
                    end
                    else begin
                        ph = gifp_pkg::PH_DONE;
                        report(gifp_pkg::ST_IMAGE, 1);
                    end
                end
                else
                    fcnt++;
            gifp_pkg::PH_LMAP:
                if (load_map_byte(b, entries_of(ext_label))) begin
                    ph = gifp_pkg::PH_DONE;
                    report(gifp_pkg::ST_IMAGE, 1);
                end
            default: ;
        endcase
    endfunction

    function void add(bit eoi, logic [7:0] b);
        byte_item_t it;
        it.eoi = eoi;
        it.b = b;
        stim.push_back(it);
    endfunction

    // size field: mostly small maps, now and then the largest
    function logic [2:0] map_bits();
        return ($urandom_range(0, 29) == 0) ? 3'd7 : 3'($urandom_range(0, 2));
    endfunction

    function void gen_file();
        logic [7:0] f[$];
        logic [7:0] flags, nb, len;
        int         n, pos;
        f = '{gifp_pkg::CH_G, gifp_pkg::CH_I, gifp_pkg::CH_F, gifp_pkg::CH_8,
              ($urandom_range(0, 1) ? gifp_pkg::CH_9 : gifp_pkg::CH_7), gifp_pkg::CH_A};
        if ($urandom_range(0, 14) == 0) begin
            pos = $urandom_range(0, 5);
            f[pos] = f[pos] ^ 8'($urandom_range(1, 255));
        end
        flags = 8'($urandom);
        flags[2:0] = map_bits();
        f.push_back(8'($urandom)); f.push_back(8'($urandom));
        f.push_back(8'($urandom)); f.push_back(8'($urandom));
        f.push_back(flags);
        f.push_back(8'($urandom));
        if (flags[7])
            repeat (3 * entries_of(flags)) f.push_back(8'($urandom));
        repeat ($urandom_range(0, 4)) begin
            case ($urandom_range(0, 3))
                0: begin
                    nb = 8'($urandom);
                    if (nb != gifp_pkg::CH_TERM && nb != gifp_pkg::CH_EXT
                        && nb != gifp_pkg::CH_IMG)
                        f.push_back(nb);
                end
                1: begin
                    f.push_back(gifp_pkg::CH_EXT);
                    f.push_back(8'($urandom));
                    repeat ($urandom_range(0, 2)) begin
                        len = 8'($urandom_range(1, 6));
                        f.push_back(len);
                        repeat (len) f.push_back(8'($urandom));
                    end
                    f.push_back(8'h00);
                end
                default: begin
                    f.push_back(gifp_pkg::CH_EXT);
                    f.push_back(gifp_pkg::LABEL_GCE);
                    len = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 6)) : 8'd4;
                    f.push_back(len);
                    repeat (len) f.push_back(8'($urandom));
                    if (len != 0) begin
                        if ($urandom_range(0, 2) == 0) begin
                            len = 8'($urandom_range(1, 5));
                            f.push_back(len);
                            repeat (len) f.push_back(8'($urandom));
                        end
                        f.push_back(8'h00);
                    end
                end
            endcase
        end
        if ($urandom_range(0, 3) == 0)
            f.push_back(gifp_pkg::CH_TERM);
        else begin
            f.push_back(gifp_pkg::CH_IMG);
            repeat (8) f.push_back(8'($urandom));
            flags = 8'($urandom);
            flags[2:0] = map_bits();
            f.push_back(flags);
            if (flags[7])
                repeat (3 * entries_of(flags)) f.push_back(8'($urandom));
        end
        // cut short some files, pad some with trailing junk
        n = f.size();
        if ($urandom_range(0, 6) == 0)
            n = $urandom_range(0, f.size() - 1);
        for (int i = 0; i < n; i++)
            add(0, f[i]);
        repeat ($urandom_range(0, 2)) add(0, 8'($urandom));
        add(1, 8'($urandom));
    endfunction

    task automatic send(byte_item_t it, int idx);
        while (!(idx >= 200 && idx < 450) && $urandom_range(0, 99) < 10) begin
            push <= 0;
            @(posedge clk);
        end
        if (idx == burst_start)
            hold_req = 1;
        push <= 1;
        action <= it.eoi;
        data_byte <= it.b;
        do @(posedge clk); while (full);
        predict(it);
    endtask

    // receiver: random stalls, one long hold-off during the end-of-input burst
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (rst_n && pop && !empty)
            board.check('{status, screen_width, screen_height, background_index,
                          color_resolution, local_map_used, transparent_valid,
                          transparent_index, transparent_rgb, disposal_method,
                          user_input_flag, delay_time});
        if (hold_req && !hold_done) begin
            pop <= 0;
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt == HOLD_CYCLES)
                hold_done <= 1;
        end
        else
            pop <= (cycle_cnt > 3000 && cycle_cnt < 5000) || $urandom_range(0, 99) >= 10;
    end

    always @(posedge clk) begin
        if (!rst_n || (push && !full) || (pop && !empty))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt == WATCHDOG_LIMIT) begin
            $display("gif_header_transparency_parser test failed");
            $finish;
        end
    end

    initial begin
        board = new();
        clear_parser();
        // directed: bare end of input, bad signature, extreme screen fields
        add(1, 8'h00);
        add(0, gifp_pkg::CH_G); add(0, gifp_pkg::CH_I); add(0, gifp_pkg::CH_F);
        add(0, gifp_pkg::CH_8); add(0, gifp_pkg::CH_8); add(0, gifp_pkg::CH_A);
        add(1, 8'hff);
        add(0, gifp_pkg::CH_G); add(0, gifp_pkg::CH_I); add(0, gifp_pkg::CH_F);
        add(0, gifp_pkg::CH_8); add(0, gifp_pkg::CH_7); add(0, gifp_pkg::CH_A);
        repeat (4) add(0, 8'hff);
        add(0, 8'h7f); add(0, 8'hff); add(0, 8'h00);
        add(0, gifp_pkg::CH_TERM);
        add(1, 8'h00);
        while (stim.size() < 550)
            gen_file();
        burst_start = stim.size();
        repeat (40) add(1, 8'($urandom));
        while (stim.size() < TARGET_ITEMS)
            gen_file();

        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        for (int i = 0; i < stim.size(); i++)
            send(stim[i], i);
        push <= 0;
        while (board.pending_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (board.mismatches == 0 && board.pending_q.size() == 0)
            $display("gif_header_transparency_parser test passed");
        else
            $display("gif_header_transparency_parser test failed");
        $finish;
    end
endmodule

[filelist.f]
hdl/gifp_pkg.sv
hdl/gifp_ram.sv
hdl/gifp_front.sv
hdl/gifp_back.sv
hdl/gif_header_transparency_parser.sv
dv/tb_gif_header_transparency_parser.sv
